// ----- hw/rtl/ptr_pkg.sv -----
`default_nettype none
package ptr_pkg;
   localparam logic [1:0] SCHEME_FIFO  = 2'd0;
   localparam logic [1:0] SCHEME_LRU   = 2'd1;
   localparam logic [1:0] SCHEME_CLOCK = 2'd2;
   localparam logic [1:0] SCHEME_NONE  = 2'd3;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;
   localparam logic [1:0] OUT_ERROR = 2'd3;

   localparam logic [1:0] REG_SCHEME = 2'd0;
   localparam logic [1:0] REG_OFFSET = 2'd1;
   localparam logic [1:0] REG_FRAMES = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic lookup;     // register lookup results of the held address
      logic scan_step;  // examine one frame (LRU min / CLOCK sweep)
      logic scan_start; // reset the scan
      logic commit;     // write table, counters, result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_scan;  // full miss with LRU or CLOCK
      logic scan_done;
   } status_type;
endpackage
`default_nettype wire

// ----- hw/rtl/ptr_if.sv -----
`default_nettype none
interface ptr_req_if #(parameter int ADDR_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [ADDR_WIDTH-1:0] logical_addr;
   modport source (output valid, output logical_addr, input ready);
   modport sink   (input valid, input logical_addr, output ready);
endinterface

interface ptr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] physical_addr;
   logic [1:0]  outcome;
   logic [3:0]  frame_index;
   logic [31:0] fault_total;
   logic [31:0] evict_total;
   modport source (output valid, output physical_addr, output outcome,
                   output frame_index, output fault_total, output evict_total,
                   input ready);
   modport sink   (input valid, input physical_addr, input outcome,
                   input frame_index, input fault_total, input evict_total,
                   output ready);
endinterface

interface ptr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ptr_ctrl.sv -----
`default_nettype none
module ptr_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   input  ptr_pkg::status_type status,
   output ptr_pkg::cmd_type    cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // result register frees when taken; a new item may start meanwhile
   wire free_out = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            cmd.lookup     = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (status.need_scan) begin
               state_in = ST_SCAN;
            end else if (free_out) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               if (free_out) begin
                  cmd.commit   = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/ptr_datapath.sv -----
`default_nettype none
module ptr_datapath #(
   parameter int MAX_FRAMES = 16,
   parameter int ADDR_WIDTH = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_take,
   input  wire  [ADDR_WIDTH-1:0] req_addr,
   input  wire  [1:0]            cfg_scheme,
   input  wire  [4:0]            cfg_offset,
   input  wire  [4:0]            cfg_frames,
   input  ptr_pkg::cmd_type      cmd,
   output ptr_pkg::status_type   status,
   output logic [31:0]           physical_addr,
   output logic [1:0]            outcome,
   output logic [3:0]            frame_index,
   output logic [31:0]           fault_total,
   output logic [31:0]           evict_total
);
   localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW = $clog2(MAX_FRAMES + 1);

   logic [ADDR_WIDTH-1:0] tag_ff [MAX_FRAMES];
   logic [31:0]           stamp_ff [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff, refb_ff;
   logic [FW-1:0]         fifo_ptr_ff, clk_ptr_ff;
   logic [31:0]           time_ff, fault_ff, evict_ff;
   logic [ADDR_WIDTH-1:0] addr_ff, page_ff, offs_ff;
   logic                  hit_ff, free_ff;
   logic [FW-1:0]         hit_idx_ff, free_idx_ff;
   logic [CW-1:0]         n_ff;
   logic [FW-1:0]         scan_ff;
   logic [FW-1:0]         best_ff;
   logic [31:0]           best_stamp_ff;
   logic                  done_ff;
   logic [31:0]           phys_ff, fault_o_ff, evict_o_ff;
   logic [1:0]            out_ff;
   logic [3:0]            fidx_ff;

   // frame count clamped to 1..MAX_FRAMES
   logic [CW-1:0] n_cur;
   always_comb begin
      if (cfg_frames == 5'd0) n_cur = CW'(1);
      else if (32'(cfg_frames) > 32'(MAX_FRAMES)) n_cur = CW'(MAX_FRAMES);
      else n_cur = CW'(cfg_frames);
   end

   logic [ADDR_WIDTH-1:0] page_c, offs_c;
   assign page_c = addr_ff >> cfg_offset;
   assign offs_c = addr_ff & ~({ADDR_WIDTH{1'b1}} << cfg_offset);

   // parallel match and first-free priority search
   logic          hit_c, free_c;
   logic [FW-1:0] hit_idx_c, free_idx_c;
   always_comb begin
      hit_c = 1'b0; free_c = 1'b0; hit_idx_c = '0; free_idx_c = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (CW'(i) < n_cur) begin
            if (valid_ff[i] && tag_ff[i] == page_c) begin
               hit_c = 1'b1; hit_idx_c = FW'(i);
            end
            if (!valid_ff[i]) begin
               free_c = 1'b1; free_idx_c = FW'(i);
            end
         end
      end
   end

   wire full_miss = !hit_ff && !free_ff;
   assign status.need_scan = full_miss && !done_ff &&
                             (cfg_scheme == ptr_pkg::SCHEME_LRU ||
                              cfg_scheme == ptr_pkg::SCHEME_CLOCK);
   assign status.scan_done = done_ff;

   wire [FW-1:0] fifo_use = (CW'(fifo_ptr_ff) >= n_ff) ? '0 : fifo_ptr_ff;
   // hand checked against the frame count of the item being looked up
   wire [FW-1:0] clk_use  = (CW'(clk_ptr_ff) >= n_cur) ? '0 : clk_ptr_ff;

   function automatic logic [FW-1:0] wrap_inc(input logic [FW-1:0] p,
                                              input logic [CW-1:0] n);
      logic [CW:0] s;
      s = {1'b0, CW'(p)} + 1'b1;
      if (s >= {1'b0, n}) return '0;
      return FW'(s);
   endfunction

   // victim and result selection at commit
   logic [FW-1:0] frame_c;
   logic [1:0]    oc_c;
   always_comb begin
      frame_c = '0;
      oc_c    = ptr_pkg::OUT_ERROR;
      if (hit_ff) begin
         frame_c = hit_idx_ff; oc_c = ptr_pkg::OUT_HIT;
      end else if (free_ff) begin
         frame_c = free_idx_ff; oc_c = ptr_pkg::OUT_FILL;
      end else begin
         case (cfg_scheme)
            ptr_pkg::SCHEME_FIFO: begin frame_c = fifo_use; oc_c = ptr_pkg::OUT_EVICT; end
            ptr_pkg::SCHEME_LRU:  begin frame_c = best_ff;  oc_c = ptr_pkg::OUT_EVICT; end
            ptr_pkg::SCHEME_CLOCK: begin frame_c = scan_ff; oc_c = ptr_pkg::OUT_EVICT; end
            default: begin frame_c = '0; oc_c = ptr_pkg::OUT_ERROR; end
         endcase
      end
   end

   wire [31:0] fault_n = hit_ff ? fault_ff : fault_ff + 32'd1;
   wire [31:0] evict_n = (oc_c == ptr_pkg::OUT_EVICT) ? evict_ff + 32'd1 : evict_ff;
   wire [63:0] phys_w  = ({{(64-FW){1'b0}}, frame_c} << cfg_offset) |
                         64'(offs_ff);

   always_ff @(posedge clock) begin
      if (req_take) addr_ff <= req_addr;
      if (cmd.lookup) begin
         hit_ff <= hit_c; free_ff <= free_c;
         hit_idx_ff <= hit_idx_c; free_idx_ff <= free_idx_c;
         page_ff <= page_c; offs_ff <= offs_c; n_ff <= n_cur;
      end
      if (cmd.scan_start) begin
         // LRU walks from frame 0, the clock sweep from the hand
         scan_ff <= (cfg_scheme == ptr_pkg::SCHEME_CLOCK) ? clk_use : '0;
         best_ff <= '0;
      end
      if (cmd.commit) begin
         phys_ff    <= (oc_c == ptr_pkg::OUT_ERROR) ? 32'd0 : phys_w[31:0];
         out_ff     <= oc_c;
         fidx_ff    <= 4'(frame_c);
         fault_o_ff <= fault_n;
         evict_o_ff <= evict_n;
         if (oc_c != ptr_pkg::OUT_ERROR && oc_c != ptr_pkg::OUT_HIT)
            tag_ff[frame_c] <= page_ff;
         if (oc_c == ptr_pkg::OUT_HIT || oc_c == ptr_pkg::OUT_FILL ||
             (oc_c == ptr_pkg::OUT_EVICT && cfg_scheme == ptr_pkg::SCHEME_LRU))
            stamp_ff[frame_c] <= time_ff;
      end
      if (cmd.scan_step) begin
         if (cfg_scheme == ptr_pkg::SCHEME_LRU) begin
            // one frame per cycle, strict less keeps lowest index on ties
            if (scan_ff == '0 || stamp_ff[scan_ff] < best_stamp_ff) begin
               best_ff <= scan_ff;
               best_stamp_ff <= stamp_ff[scan_ff];
            end
            scan_ff <= wrap_inc(scan_ff, n_ff);
         end else begin
            if (refb_ff[scan_ff]) scan_ff <= wrap_inc(scan_ff, n_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         refb_ff     <= '0;
         fifo_ptr_ff <= '0;
         clk_ptr_ff  <= '0;
         time_ff     <= '0;
         fault_ff    <= '0;
         evict_ff    <= '0;
         done_ff     <= 1'b0;
      end else begin
         if (cmd.scan_start) done_ff <= 1'b0;
         if (cmd.scan_step) begin
            if (cfg_scheme == ptr_pkg::SCHEME_LRU) begin
               if (CW'(scan_ff) + CW'(1) >= n_ff) done_ff <= 1'b1;
            end else begin
               if (refb_ff[scan_ff]) refb_ff[scan_ff] <= 1'b0;
               else done_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            time_ff  <= time_ff + 32'd1;
            fault_ff <= fault_n;
            evict_ff <= evict_n;
            if (oc_c == ptr_pkg::OUT_HIT || oc_c == ptr_pkg::OUT_FILL)
               refb_ff[frame_c] <= 1'b1;
            if (oc_c == ptr_pkg::OUT_FILL) valid_ff[frame_c] <= 1'b1;
            if (oc_c == ptr_pkg::OUT_EVICT) begin
               if (cfg_scheme == ptr_pkg::SCHEME_FIFO)
                  fifo_ptr_ff <= wrap_inc(fifo_use, n_ff);
               if (cfg_scheme == ptr_pkg::SCHEME_CLOCK) begin
                  refb_ff[frame_c] <= 1'b1;
                  clk_ptr_ff <= wrap_inc(scan_ff, n_ff);
               end
            end
         end
      end
   end

   assign physical_addr = phys_ff;
   assign outcome       = out_ff;
   assign frame_index   = fidx_ff;
   assign fault_total   = fault_o_ff;
   assign evict_total   = evict_o_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/page_translate_with_replacement_top.sv -----
`default_nettype none
// An accepted item is looked up, then committed from ST_DONE on hit, fill,
// FIFO or error; LRU misses first scan every frame, CLOCK misses first sweep the
// hand past set reference bits. Commit waits until the result register is free.
// The single lookup/commit sequencer holds one item at a time. Reset
// (synchronous) frees all frames, zeroes pointers, time and counters, and
// restores 0/12/16.
module page_translate_with_replacement_top #(
   parameter int MAX_FRAMES = 16,
   parameter int ADDR_WIDTH = 32
) (
   input wire       clock,
   input wire       reset,
   ptr_req_if.sink  req,
   ptr_rsp_if.source rsp,
   ptr_csr_if.sink  csr
);
   logic [1:0] scheme_ff;
   logic [4:0] offset_ff, frames_ff;

   // configuration is always writable
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= ptr_pkg::SCHEME_FIFO;
         offset_ff <= 5'd12;
         frames_ff <= 5'd16;
      end else if (csr.valid) begin
         unique case (csr.index)
            ptr_pkg::REG_SCHEME: scheme_ff <= csr.data[1:0];
            ptr_pkg::REG_OFFSET: offset_ff <= csr.data[4:0];
            ptr_pkg::REG_FRAMES: frames_ff <= csr.data[4:0];
            default: ;
         endcase
      end
   end

   ptr_pkg::cmd_type    cmd;
   ptr_pkg::status_type status;

   ptr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ptr_datapath #(.MAX_FRAMES(MAX_FRAMES), .ADDR_WIDTH(ADDR_WIDTH)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_take      (req.valid && req.ready),
      .req_addr      (req.logical_addr),
      .cfg_scheme    (scheme_ff),
      .cfg_offset    (offset_ff),
      .cfg_frames    (frames_ff),
      .cmd           (cmd),
      .status        (status),
      .physical_addr (rsp.physical_addr),
      .outcome       (rsp.outcome),
      .frame_index   (rsp.frame_index),
      .fault_total   (rsp.fault_total),
      .evict_total   (rsp.evict_total)
   );
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] physical_addr;
      logic [1:0]  outcome;
      logic [3:0]  frame_index;
      logic [31:0] fault_total;
      logic [31:0] evict_total;
   } xlat_type;

   // one directed stimulus row; chk set means the typed result is compared too
   typedef struct {
      logic [31:0] addr;
      bit          chk;
      xlat_type    res;
   } row_type;

   localparam int NFR = 16;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ptr_req_if #(.ADDR_WIDTH(32)) req ();
   ptr_rsp_if rsp ();
   ptr_csr_if csr ();

   page_translate_with_replacement_top #(.MAX_FRAMES(NFR), .ADDR_WIDTH(32)) DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------- predictor state (mirror of the frame table) ----------------
   logic [31:0] tag_m [NFR];
   bit          vld_m [NFR];
   bit          refb_m [NFR];
   logic [31:0] stamp_m [NFR];
   int unsigned fifo_ptr, clk_hand;
   logic [31:0] now_m, faults_m, evicts_m;
   logic [1:0]  scheme_m;
   logic [4:0]  obits_m, nfr_cfg_m;

   xlat_type translations_due [$];
   int    errors = 0;
   int    results_seen = 0;
   int    cycles = 0;
   int    idle_src = 0;   // percent of cycles the sender idles
   int    idle_snk = 0;   // percent of cycles the receiver stalls
   int    by_outcome [4] = '{0, 0, 0, 0};

   function automatic void table_clear();
      for (int i = 0; i < NFR; i++) begin
         tag_m[i] = '0; vld_m[i] = 0; refb_m[i] = 0; stamp_m[i] = '0;
      end
      fifo_ptr = 0; clk_hand = 0;
      now_m = '0; faults_m = '0; evicts_m = '0;
      scheme_m = ptr_pkg::SCHEME_FIFO; obits_m = 5'd12; nfr_cfg_m = 5'd16;
   endfunction

   // Translate one address and update the mirrored table; returns the expected item.
   function automatic xlat_type translate(logic [31:0] addr);
      xlat_type r;
      logic [31:0] page, offs, best;
      int unsigned n, fr;
      bit hit;
      logic [1:0] oc;
      n = (nfr_cfg_m < 1) ? 1 : (nfr_cfg_m > NFR) ? NFR : nfr_cfg_m;
      page = addr >> obits_m;
      offs = addr & ((32'd1 << obits_m) - 32'd1);
      hit = 0; fr = 0; oc = ptr_pkg::OUT_ERROR;
      for (int i = 0; i < n; i++)
         if (!hit && vld_m[i] && tag_m[i] == page) begin
            hit = 1; fr = i;
         end
      if (hit) begin
         stamp_m[fr] = now_m; refb_m[fr] = 1; oc = ptr_pkg::OUT_HIT;
      end else begin
         faults_m++;
         for (int i = 0; i < n; i++)
            if (!hit && !vld_m[i]) begin
               hit = 1; fr = i;
            end
         if (hit) begin
            tag_m[fr] = page; vld_m[fr] = 1; stamp_m[fr] = now_m; refb_m[fr] = 1;
            oc = ptr_pkg::OUT_FILL;
         end else if (scheme_m == ptr_pkg::SCHEME_FIFO) begin
            if (fifo_ptr >= n) fifo_ptr = 0;
            fr = fifo_ptr; tag_m[fr] = page;
            fifo_ptr = (fifo_ptr + 1) % n;
            oc = ptr_pkg::OUT_EVICT;
         end else if (scheme_m == ptr_pkg::SCHEME_LRU) begin
            best = stamp_m[0]; fr = 0;
            for (int i = 1; i < n; i++)
               if (stamp_m[i] < best) begin
                  best = stamp_m[i]; fr = i;
               end
            tag_m[fr] = page; stamp_m[fr] = now_m;
            oc = ptr_pkg::OUT_EVICT;
         end else if (scheme_m == ptr_pkg::SCHEME_CLOCK) begin
            if (clk_hand >= n) clk_hand = 0;
            while (refb_m[clk_hand]) begin
               refb_m[clk_hand] = 0;
               clk_hand = (clk_hand + 1) % n;
            end
            fr = clk_hand; tag_m[fr] = page; refb_m[fr] = 1;
            clk_hand = (clk_hand + 1) % n;
            oc = ptr_pkg::OUT_EVICT;
         end else begin
            fr = 0; oc = ptr_pkg::OUT_ERROR;
         end
         if (oc == ptr_pkg::OUT_EVICT) evicts_m++;
      end
      r.physical_addr = (oc == ptr_pkg::OUT_ERROR) ? 32'd0 : ((32'(fr) << obits_m) | offs);
      r.outcome = oc;
      r.frame_index = fr[3:0];
      r.fault_total = faults_m;
      r.evict_total = evicts_m;
      now_m++;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("ERROR item %0d: %s got 0x%08h expected 0x%08h", results_seen, what, got, want);
   endtask

   // ---------------- drivers ----------------
   initial begin
      req.valid = 1'b0; req.logical_addr = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.index = ptr_pkg::REG_SCHEME; csr.data = '0;
   end

   // Receiver: stall at random per the current idle percentage.
   always @(posedge clock) begin
      if (reset)
         rsp.ready <= 1'b0;
      else
         rsp.ready <= ($urandom_range(99) >= idle_snk);
   end

   // Checker: compare each accepted item with the oldest expected translation.
   always @(posedge clock) begin
      xlat_type got, want;
      cycles++;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.physical_addr, rsp.outcome, rsp.frame_index,
                 rsp.fault_total, rsp.evict_total};
         if (translations_due.size() == 0) begin
            errors++;
            $display("ERROR: result with nothing expected");
         end else begin
            want = translations_due.pop_front();
            if (got.physical_addr !== want.physical_addr)
               report_mismatch("physical_addr", got.physical_addr, want.physical_addr);
            if (got.outcome !== want.outcome)
               report_mismatch("outcome", 32'(got.outcome), 32'(want.outcome));
            if (got.frame_index !== want.frame_index)
               report_mismatch("frame_index", 32'(got.frame_index), 32'(want.frame_index));
            if (got.fault_total !== want.fault_total)
               report_mismatch("fault_total", got.fault_total, want.fault_total);
            if (got.evict_total !== want.evict_total)
               report_mismatch("evict_total", got.evict_total, want.evict_total);
            by_outcome[want.outcome]++;
         end
         results_seen++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Send one address; random idle cycles ahead of it. Valid stays high after the
   // accept; the next send, an idle cycle or a drain decides its next value.
   task automatic send_addr(logic [31:0] addr, bit chk, xlat_type typed);
      xlat_type pred;
      while ($urandom_range(99) < idle_src) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.logical_addr <= addr;
      pred = translate(addr);
      if (chk && pred !== typed) begin
         errors++;
         $display("ERROR: directed row 0x%08h disagrees with its typed result", addr);
      end
      translations_due.push_back(pred);
      do @(posedge clock); while (!req.ready);
   endtask

   // Idle point: let every result drain, then keep idling past the block's worst scan time.
   task automatic drain();
      req.valid <= 1'b0;
      while (translations_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr.valid <= 1'b1; csr.index <= idx; csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      @(posedge clock);
      case (idx)
         ptr_pkg::REG_SCHEME: scheme_m = val[1:0];
         ptr_pkg::REG_OFFSET: obits_m = val[4:0];
         ptr_pkg::REG_FRAMES: nfr_cfg_m = val[4:0];
         default: ;
      endcase
   endtask

   // Pages are drawn from a small pool so hits, fills and evictions all recur.
   function automatic logic [31:0] pick_addr(int pool);
      logic [31:0] a;
      a = $urandom;
      if ($urandom_range(9) == 0)
         return a;  // fully random noise address
      return (a & ((32'd1 << obits_m) - 1)) | (32'($urandom_range(pool - 1)) << obits_m)
             | (($urandom_range(3) == 0) ? 32'h8000_0000 : 32'd0);
   endfunction

   task automatic random_phase(int count, logic [1:0] sch, logic [4:0] ob, logic [4:0] nf);
      int pool;
      xlat_type none;
      none = '0;
      drain();
      write_reg(ptr_pkg::REG_SCHEME, 32'(sch));
      write_reg(ptr_pkg::REG_OFFSET, 32'(ob));
      write_reg(ptr_pkg::REG_FRAMES, 32'(nf));
      pool = ((nf == 0) ? 1 : (nf > NFR ? NFR : nf)) + $urandom_range(1, 6);
      for (int i = 0; i < count; i++)
         send_addr(pick_addr(pool), 0, none);
   endtask

   // ---------------- test sequence ----------------
   initial begin
      row_type dir [$];
      xlat_type none;
      none = '0;
      table_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset defaults (FIFO, 12 offset bits, 16 frames).
      // Fills of pages 0 and all-ones, then a hit on each, typed in full.
      dir.push_back('{32'h0000_0000, 1,
                      '{32'h0000_0000, ptr_pkg::OUT_FILL, 4'd0, 32'd1, 32'd0}});
      dir.push_back('{32'hFFFF_FFFF, 1,
                      '{32'h0000_1FFF, ptr_pkg::OUT_FILL, 4'd1, 32'd2, 32'd0}});
      dir.push_back('{32'h0000_0ABC, 1,
                      '{32'h0000_0ABC, ptr_pkg::OUT_HIT,  4'd0, 32'd2, 32'd0}});
      dir.push_back('{32'hFFFF_F000, 1,
                      '{32'h0000_1000, ptr_pkg::OUT_HIT,  4'd1, 32'd2, 32'd0}});
      foreach (dir[i]) send_addr(dir[i].addr, dir[i].chk, dir[i].res);

      // Fill the remaining frames, then FIFO evictions advance the pointer.
      for (int p = 2; p < 20; p++) send_addr(32'(p) << 12, 0, none);

      // No scheme with a full table: error item, fault counted, no eviction.
      drain();
      write_reg(ptr_pkg::REG_SCHEME, 32'(ptr_pkg::SCHEME_NONE));
      send_addr(32'h1234_5678, 0, none);
      send_addr(32'h0000_2000, 0, none);   // page 2 was evicted, so another error item
      // Shrink frames below the FIFO pointer position and use every offset extreme.
      drain();
      write_reg(ptr_pkg::REG_FRAMES, 32'd0);        // acts as one frame
      write_reg(ptr_pkg::REG_OFFSET, 32'd31);
      write_reg(ptr_pkg::REG_SCHEME, 32'(ptr_pkg::SCHEME_CLOCK));
      send_addr(32'h8000_0001, 0, none);
      send_addr(32'h0000_0001, 0, none);
      drain();
      write_reg(ptr_pkg::REG_OFFSET, 32'd0);
      write_reg(ptr_pkg::REG_FRAMES, 32'd31);       // clamps to the maximum
      write_reg(ptr_pkg::REG_SCHEME, 32'(ptr_pkg::SCHEME_LRU));
      send_addr(32'hDEAD_BEEF, 0, none);
      send_addr(32'h0000_0005, 0, none);

      // Random phases over schemes, offsets and frame counts, three idle profiles.
      idle_src = 33; idle_snk = 66;
      random_phase(120, ptr_pkg::SCHEME_FIFO,  5'd12, 5'd4);
      random_phase(130, ptr_pkg::SCHEME_LRU,   5'd1,  5'd16);
      random_phase(130, ptr_pkg::SCHEME_CLOCK, 5'd20, 5'd3);
      drain();   // sender holds off until every result is back
      idle_src = 66; idle_snk = 33;
      random_phase(130, ptr_pkg::SCHEME_NONE,  5'd8,  5'd2);
      random_phase(130, ptr_pkg::SCHEME_CLOCK, 5'd31, 5'd16);
      random_phase(120, ptr_pkg::SCHEME_LRU,   5'd6,  5'd1);
      idle_src = 0; idle_snk = 0;
      random_phase(130, ptr_pkg::SCHEME_FIFO,  5'd3,  5'd16);
      random_phase(130, ptr_pkg::SCHEME_LRU,   5'd16, 5'd7);
      random_phase(120, ptr_pkg::SCHEME_CLOCK, 5'd0,  5'd5);

      drain();
      $display("Covered %0d translations: %0d hits, %0d fills, %0d evictions, %0d errors",
               results_seen, by_outcome[0], by_outcome[1], by_outcome[2], by_outcome[3]);
      $display("All replacement schemes, offset widths 0..31 and frame counts 0..31 used");
      if (errors == 0 && translations_due.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
